// ===== rtl/rgb_to_hsv_convert_top_macros.svh =====
// ----------------------------------------------------------------------------
// rgb_to_hsv_convert_top_macros.svh
// assertion macros used by the rgb to hsv converter top
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_CONVERT_TOP_MACROS_SVH
`define RGB_TO_HSV_CONVERT_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the same cycle
`define RHC_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// expression must never be true
`define RHC_ASSERT_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("assertion failed");

`else

`define RHC_ASSERT_IMPL(lbl, ante, cons)
`define RHC_ASSERT_NEVER(lbl, expr)

`endif

`endif

// ===== rtl/rhc_pkg.sv =====
// ----------------------------------------------------------------------------
// rhc_pkg
// types, constants and divider step functions for the rgb to hsv converter
// ----------------------------------------------------------------------------
`default_nettype none

package rhc_pkg;

	localparam int PIX_W = 8;
	localparam int HUE_W = 15;
	// quotient bits; hue quotient reaches 3840
	localparam int Q_W = 12;
	localparam int NUM_W = PIX_W + Q_W;
	localparam int BITS_PER_STAGE = 3;
	localparam int DIV_STAGES = Q_W / BITS_PER_STAGE;

	localparam logic [HUE_W-1:0] HUE_RED = 15'd0;
	localparam logic [HUE_W-1:0] HUE_GREEN = 15'd7680;
	localparam logic [HUE_W-1:0] HUE_BLUE = 15'd15360;
	localparam logic [HUE_W-1:0] HUE_FULL = 15'd23040;

	// partial restoring division state
	typedef struct packed {
		logic [PIX_W-1:0] rem;
		logic [Q_W-1:0]   num;
		logic [PIX_W-1:0] den;
		logic [Q_W-1:0]   quo;
	} div_t;

	// per-pixel data that rides along with the division
	typedef struct packed {
		logic [HUE_W-1:0] base;
		logic             neg;
		logic             gray;
		logic [PIX_W-1:0] val;
	} side_t;

	// load a numerator whose quotient fits in Q_W bits
	function automatic div_t div_init(input logic [NUM_W-1:0] n, input logic [PIX_W-1:0] d);
		div_t x;
		x.rem = n[NUM_W-1:Q_W];
		x.num = n[Q_W-1:0];
		x.den = d;
		x.quo = '0;
		return x;
	endfunction

	// one quotient bit
	function automatic div_t div_step(input div_t x);
		div_t y;
		logic [PIX_W:0] t;
		t = {x.rem, x.num[Q_W-1]};
		y = x;
		y.num = {x.num[Q_W-2:0], 1'b0};
		if (t >= {1'b0, x.den}) begin
			y.rem = PIX_W'(t - {1'b0, x.den});
			y.quo = {x.quo[Q_W-2:0], 1'b1};
		end else begin
			y.rem = t[PIX_W-1:0];
			y.quo = {x.quo[Q_W-2:0], 1'b0};
		end
		return y;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/rhc_front.sv =====
// ----------------------------------------------------------------------------
// rhc_front
// max/min sorting, hue sector selection and divider numerator setup
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [rhc_pkg::PIX_W-1:0]      red,
	input  wire logic [rhc_pkg::PIX_W-1:0]      green,
	input  wire logic [rhc_pkg::PIX_W-1:0]      blue,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output rhc_pkg::side_t                      out_side,
	output rhc_pkg::div_t                       out_hue,
	output rhc_pkg::div_t                       out_sat
);

	logic                        v_s1, v_s2;
	logic                        ready_s1, ready_s2;
	logic [rhc_pkg::PIX_W-1:0]   mx, mn, a, b, delta, mag;
	logic [rhc_pkg::HUE_W-1:0]   base;
	logic                        neg;
	logic [rhc_pkg::PIX_W-1:0]   val_s1, delta_s1, mag_s1;
	logic [rhc_pkg::HUE_W-1:0]   base_s1;
	logic                        neg_s1;
	logic [rhc_pkg::NUM_W-1:0]   hue_num, sat_num;
	rhc_pkg::side_t              side_s2;
	rhc_pkg::div_t               hue_s2, sat_s2;

	assign ready_s2 = !v_s2 || out_ready;
	assign ready_s1 = !v_s1 || ready_s2;
	assign in_ready = ready_s1;

	// sector select, ties go to red then green
	always_comb begin
		if (red >= green && red >= blue) begin
			mx = red;
			base = rhc_pkg::HUE_RED;
			a = green;
			b = blue;
		end else if (green >= blue) begin
			mx = green;
			base = rhc_pkg::HUE_GREEN;
			a = blue;
			b = red;
		end else begin
			mx = blue;
			base = rhc_pkg::HUE_BLUE;
			a = red;
			b = green;
		end
		mn = red;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		delta = mx - mn;
		neg = a < b;
		mag = neg ? (b - a) : (a - b);
	end

	// stage 1 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ready_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			val_s1 <= mx;
			delta_s1 <= delta;
			mag_s1 <= mag;
			neg_s1 <= neg;
			base_s1 <= base;
		end
	end

	// numerators: 3840 * mag and 255 * delta
	always_comb begin
		hue_num = {mag_s1, 12'd0} - {4'd0, mag_s1, 8'd0};
		sat_num = {4'd0, delta_s1, 8'd0} - {12'd0, delta_s1};
	end

	// stage 2 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ready_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && v_s1) begin
			side_s2.base <= base_s1;
			side_s2.neg <= neg_s1;
			side_s2.gray <= (delta_s1 == '0);
			side_s2.val <= val_s1;
			hue_s2 <= rhc_pkg::div_init(hue_num, delta_s1);
			sat_s2 <= rhc_pkg::div_init(sat_num, val_s1);
		end
	end

	assign out_valid = v_s2;
	assign out_side = side_s2;
	assign out_hue = hue_s2;
	assign out_sat = sat_s2;

endmodule

`default_nettype wire

// ===== rtl/rhc_div_stage.sv =====
// ----------------------------------------------------------------------------
// rhc_div_stage
// one pipeline stage of the hue and saturation dividers, several bits per stage
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_div_stage (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire rhc_pkg::side_t in_side,
	input  wire rhc_pkg::div_t  in_hue,
	input  wire rhc_pkg::div_t  in_sat,
	output logic                out_valid,
	input  wire logic           out_ready,
	output rhc_pkg::side_t      out_side,
	output rhc_pkg::div_t       out_hue,
	output rhc_pkg::div_t       out_sat
);

	logic           v_q;
	rhc_pkg::side_t side_q;
	rhc_pkg::div_t  hue_q, sat_q;
	rhc_pkg::div_t  hue_nx, sat_nx;

	assign in_ready = !v_q || out_ready;

	// a few quotient bits of each division
	always_comb begin
		hue_nx = in_hue;
		sat_nx = in_sat;
		for (int i = 0; i < rhc_pkg::BITS_PER_STAGE; i++) begin
			hue_nx = rhc_pkg::div_step(hue_nx);
			sat_nx = rhc_pkg::div_step(sat_nx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			side_q <= in_side;
			hue_q <= hue_nx;
			sat_q <= sat_nx;
		end
	end

	assign out_valid = v_q;
	assign out_side = side_q;
	assign out_hue = hue_q;
	assign out_sat = sat_q;

endmodule

`default_nettype wire

// ===== rtl/rhc_finish.sv =====
// ----------------------------------------------------------------------------
// rhc_finish
// hue offset and wrap, black and gray handling, output register
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_finish (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire rhc_pkg::side_t             in_side,
	input  wire rhc_pkg::div_t              in_hue,
	input  wire rhc_pkg::div_t              in_sat,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [rhc_pkg::HUE_W-1:0]       hue,
	output logic [rhc_pkg::PIX_W-1:0]       sat,
	output logic [rhc_pkg::PIX_W-1:0]       val
);

	logic                      v_s7;
	logic [rhc_pkg::HUE_W-1:0] hue_s7, hue_nx, qx;
	logic [rhc_pkg::PIX_W-1:0] sat_s7, val_s7, sat_nx;

	assign in_ready = !v_s7 || out_ready;

	// base plus or minus quotient, negative wraps by a full turn; gray gives hue zero, black gives zero saturation
	always_comb begin
		qx = {{(rhc_pkg::HUE_W - rhc_pkg::Q_W){1'b0}}, in_hue.quo};
		if (in_side.gray) begin
			hue_nx = '0;
		end else if (!in_side.neg) begin
			hue_nx = in_side.base + qx;
		end else if (qx > in_side.base) begin
			hue_nx = rhc_pkg::HUE_FULL - qx + in_side.base;
		end else begin
			hue_nx = in_side.base - qx;
		end
		sat_nx = (in_side.val == '0) ? '0 : in_sat.quo[rhc_pkg::PIX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (in_ready) begin
			v_s7 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			hue_s7 <= hue_nx;
			sat_s7 <= sat_nx;
			val_s7 <= in_side.val;
		end
	end

	assign out_valid = v_s7;
	assign hue = hue_s7;
	assign sat = sat_s7;
	assign val = val_s7;

endmodule

`default_nettype wire

// ===== rtl/rgb_to_hsv_convert_top.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hsv_convert_top
// streaming 8-bit rgb to hsv converter, when not stalled one pixel per clock
// ----------------------------------------------------------------------------
// Takes one pixel per clock while the output is not stalled, and returns hue
// (1/64 degree), saturation (0..255) and value after the pixel has passed
// through every stage: two stages sort the channels and form the divider
// numerators, four stages run the hue and saturation divisions three quotient
// bits each, and one stage applies the hue offset and holds the result. Every
// stage has its own valid bit and stalls only when the stage after it is full,
// so a stalled output does not block input until the pipeline has filled up.
`default_nettype none

`include "rgb_to_hsv_convert_top_macros.svh"

module rgb_to_hsv_convert_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// red_in [7:0], green_in [15:8], blue_in [23:16]
	input  wire logic [23:0] s_axis_tdata,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// hue_out [14:0], sat_out [22:15], val_out [30:23], zero [31]
	output logic [31:0]      m_axis_tdata
);

	localparam int NS = rhc_pkg::DIV_STAGES;

	logic                      v [NS+1];
	logic                      rdy [NS+1];
	rhc_pkg::side_t            side [NS+1];
	rhc_pkg::div_t             hue_d [NS+1];
	rhc_pkg::div_t             sat_d [NS+1];
	logic [rhc_pkg::HUE_W-1:0] hue_out;
	logic [rhc_pkg::PIX_W-1:0] sat_out, val_out;

	// sorting and numerator setup
	rhc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.red       (s_axis_tdata[7:0]),
		.green     (s_axis_tdata[15:8]),
		.blue      (s_axis_tdata[23:16]),
		.out_valid (v[0]),
		.out_ready (rdy[0]),
		.out_side  (side[0]),
		.out_hue   (hue_d[0]),
		.out_sat   (sat_d[0])
	);

	// divider pipeline
	for (genvar i = 0; i < NS; i++) begin : g_div
		rhc_div_stage u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (v[i]),
			.in_ready  (rdy[i]),
			.in_side   (side[i]),
			.in_hue    (hue_d[i]),
			.in_sat    (sat_d[i]),
			.out_valid (v[i+1]),
			.out_ready (rdy[i+1]),
			.out_side  (side[i+1]),
			.out_hue   (hue_d[i+1]),
			.out_sat   (sat_d[i+1])
		);
	end

	// hue offset and output word
	rhc_finish u_finish (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v[NS]),
		.in_ready  (rdy[NS]),
		.in_side   (side[NS]),
		.in_hue    (hue_d[NS]),
		.in_sat    (sat_d[NS]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.hue       (hue_out),
		.sat       (sat_out),
		.val       (val_out)
	);

	assign m_axis_tdata = {1'b0, val_out, sat_out, hue_out};

	// assertions
	`RHC_ASSERT_IMPL(a_hue_range, m_axis_tvalid, m_axis_tdata[14:0] < rhc_pkg::HUE_FULL)
	`RHC_ASSERT_IMPL(a_black, m_axis_tvalid && m_axis_tdata[30:23] == 8'd0, m_axis_tdata[22:0] == 23'd0)
	`RHC_ASSERT_IMPL(a_gray_hue, m_axis_tvalid && m_axis_tdata[22:15] == 8'd0, m_axis_tdata[14:0] == 15'd0)
	`RHC_ASSERT_NEVER(a_empty_ready, !m_axis_tvalid && !s_axis_tready)

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the streaming rgb to hsv converter
// ----------------------------------------------------------------------------
// Pixels are fed from a queue through a driver process, and each accepted word
// is converted by an independent model into its expected hue, saturation and
// value. A monitor compares every output word, field by field, with the oldest
// expectation. A directed set covers black, gray, pure and tied colors and the
// hue wrap. Random pixels follow through phases of no idling, sender gaps,
// receiver stalls and both together, plus one long receiver hold-off.
module testbench;

	localparam int PIX_W = rhc_pkg::PIX_W;
	localparam int HUE_W = rhc_pkg::HUE_W;
	localparam int CLK_HALF = 4;
	localparam int HUE_SIXTH = 3840;
	localparam int HOLD_CYCLES = 120;
	localparam int TAIL_CYCLES = 20;
	localparam int DRAIN_GUARD = 5000;

	// red in the low byte, matching the input word layout
	typedef struct packed {
		logic [PIX_W-1:0] blue;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] red;
	} pixel_t;

	typedef struct {
		logic [HUE_W-1:0] hue;
		logic [PIX_W-1:0] sat;
		logic [PIX_W-1:0] val;
	} hsv_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	// red_in [7:0], green_in [15:8], blue_in [23:16]
	logic [23:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// hue_out [14:0], sat_out [22:15], val_out [30:23], zero [31]
	logic [31:0] m_axis_tdata;

	pixel_t pending_pixels[$];
	hsv_t   expected_hsv[$];
	hsv_t   oldest_hsv;
	int     send_idle_pct = 0;
	int     ready_stall_pct = 0;
	logic   hold_off = 1'b0;
	logic   pressure_go = 1'b0;
	int     mismatch_count = 0;

	rgb_to_hsv_convert_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #CLK_HALF clk = ~clk;

	// hue within one sector: base plus or minus the scaled channel difference
	function automatic int sector_hue(int base, int a, int b, int delta);
		if (a >= b)
			return base + (HUE_SIXTH * (a - b)) / delta;
		return base - (HUE_SIXTH * (b - a)) / delta;
	endfunction

	function automatic hsv_t convert_pixel(pixel_t px);
		int   r;
		int   g;
		int   b;
		int   top;
		int   bottom;
		int   delta;
		int   hue_v;
		hsv_t res;
		r = px.red;
		g = px.green;
		b = px.blue;
		top = r;
		if (g > top) top = g;
		if (b > top) top = b;
		bottom = r;
		if (g < bottom) bottom = g;
		if (b < bottom) bottom = b;
		delta = top - bottom;
		hue_v = 0;
		res.sat = '0;
		if (top != 0) begin
			res.sat = PIX_W'((255 * delta) / top);
			// ties go to red first, then green
			if (delta != 0) begin
				if (top == r)
					hue_v = sector_hue(int'(rhc_pkg::HUE_RED), g, b, delta);
				else if (top == g)
					hue_v = sector_hue(int'(rhc_pkg::HUE_GREEN), b, r, delta);
				else
					hue_v = sector_hue(int'(rhc_pkg::HUE_BLUE), r, g, delta);
				if (hue_v < 0)
					hue_v += int'(rhc_pkg::HUE_FULL);
			end
		end
		res.hue = HUE_W'(hue_v);
		res.val = PIX_W'(top);
		return res;
	endfunction

	// mostly uniform pixels, with grays and tied maxima mixed in
	function automatic pixel_t random_pixel();
		pixel_t px;
		logic [PIX_W-1:0] v;
		logic [PIX_W-1:0] o;
		v = PIX_W'($urandom_range(255));
		o = PIX_W'($urandom_range(int'(v)));
		case ($urandom_range(7))
			0: px = '{blue: v, green: v, red: v};
			1: begin
				case ($urandom_range(2))
					0: px = '{blue: o, green: v, red: v};
					1: px = '{blue: v, green: v, red: o};
					default: px = '{blue: v, green: o, red: v};
				endcase
			end
			default: px = pixel_t'(24'($urandom));
		endcase
		return px;
	endfunction

	task automatic report_field(string name, int want, int got);
		mismatch_count++;
		$error("%s mismatch: expected %0d, got %0d", name, want, got);
	endtask

	// sender: holds a word until accepted, gaps at random between words
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				expected_hsv.push_back(convert_pixel(pixel_t'(s_axis_tdata)));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= pending_pixels.pop_front();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: checks each accepted word and stalls at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_hsv.size() == 0) begin
					mismatch_count++;
					$error("result word 0x%08h with no pixel pending", m_axis_tdata);
				end else begin
					oldest_hsv = expected_hsv.pop_front();
					if (m_axis_tdata[14:0] !== oldest_hsv.hue)
						report_field("hue_out", oldest_hsv.hue, m_axis_tdata[14:0]);
					if (m_axis_tdata[22:15] !== oldest_hsv.sat)
						report_field("sat_out", oldest_hsv.sat, m_axis_tdata[22:15]);
					if (m_axis_tdata[30:23] !== oldest_hsv.val)
						report_field("val_out", oldest_hsv.val, m_axis_tdata[30:23]);
				end
			end
			m_axis_tready <= !hold_off && ($urandom_range(99) >= ready_stall_pct);
		end
	end

	// long receiver hold-off so the pipeline fills and back-pressures input
	initial begin
		while (!pressure_go)
			@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	task automatic run_phase(int idle_pct, int stall_pct, int count, logic squeeze);
		@(posedge clk);
		send_idle_pct <= idle_pct;
		ready_stall_pct <= stall_pct;
		pressure_go <= squeeze;
		for (int i = 0; i < count; i++)
			pending_pixels.push_back(random_pixel());
		while (pending_pixels.size() != 0)
			@(posedge clk);
	endtask

	// stimulus
	initial begin
		int guard;
		pending_pixels.push_back('{blue: 8'd0,   green: 8'd0,   red: 8'd0});
		pending_pixels.push_back('{blue: 8'd255, green: 8'd255, red: 8'd255});
		pending_pixels.push_back('{blue: 8'd128, green: 8'd128, red: 8'd128});
		pending_pixels.push_back('{blue: 8'd0,   green: 8'd0,   red: 8'd255});
		pending_pixels.push_back('{blue: 8'd0,   green: 8'd255, red: 8'd0});
		pending_pixels.push_back('{blue: 8'd255, green: 8'd0,   red: 8'd0});
		pending_pixels.push_back('{blue: 8'd0,   green: 8'd255, red: 8'd255});
		pending_pixels.push_back('{blue: 8'd255, green: 8'd255, red: 8'd0});
		pending_pixels.push_back('{blue: 8'd255, green: 8'd0,   red: 8'd255});
		pending_pixels.push_back('{blue: 8'd1,   green: 8'd0,   red: 8'd255});
		pending_pixels.push_back('{blue: 8'd0,   green: 8'd1,   red: 8'd255});
		pending_pixels.push_back('{blue: 8'd0,   green: 8'd0,   red: 8'd1});
		pending_pixels.push_back('{blue: 8'd0,   green: 8'd1,   red: 8'd1});
		pending_pixels.push_back('{blue: 8'd1,   green: 8'd1,   red: 8'd0});
		pending_pixels.push_back('{blue: 8'd1,   green: 8'd0,   red: 8'd1});
		pending_pixels.push_back('{blue: 8'd1,   green: 8'd0,   red: 8'd0});
		pending_pixels.push_back('{blue: 8'd150, green: 8'd100, red: 8'd200});
		pending_pixels.push_back('{blue: 8'd50,  green: 8'd200, red: 8'd100});
		pending_pixels.push_back('{blue: 8'd200, green: 8'd100, red: 8'd50});
		pending_pixels.push_back('{blue: 8'd255, green: 8'd255, red: 8'd254});
		pending_pixels.push_back('{blue: 8'd254, green: 8'd128, red: 8'd255});
		pending_pixels.push_back('{blue: 8'd255, green: 8'd20,  red: 8'd10});
		pending_pixels.push_back('{blue: 8'd0,   green: 8'd254, red: 8'd255});

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_pixels.size() != 0)
			@(posedge clk);

		run_phase(0, 0, 140, 1'b1);
		run_phase(62, 0, 130, 1'b0);
		run_phase(0, 62, 130, 1'b0);
		run_phase(32, 32, 130, 1'b0);

		// drain the pipeline
		while (s_axis_tvalid || hold_off)
			@(posedge clk);
		guard = 0;
		while (expected_hsv.size() != 0 && guard < DRAIN_GUARD) begin
			@(posedge clk);
			guard++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_hsv.size() != 0) begin
			mismatch_count++;
			$error("%0d pixels never produced a result", expected_hsv.size());
		end

		if (mismatch_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
